FILE: hdl/bal_pkg.sv
// Shared types and constants for the bounded array list.
package bal_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 5;
  localparam int CNT_OUT_W = 6;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_READ   = 2'd3
  } bal_op_t;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_LEFT  = 2'd2,
    CELL_RIGHT = 2'd3
  } bal_cell_mode_t;

endpackage

FILE: hdl/bal_cell.sv
// One storage cell of the list: holds one entry and trades it with its neighbors.
module bal_cell (
  input  logic                          clk,
  input  bal_pkg::bal_cell_mode_t       mode,
  input  logic signed [bal_pkg::DATA_W-1:0] load_data,
  input  logic signed [bal_pkg::DATA_W-1:0] left_data,
  input  logic signed [bal_pkg::DATA_W-1:0] right_data,
  output logic signed [bal_pkg::DATA_W-1:0] q
);
  import bal_pkg::*;

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  always_comb begin
    case (mode)
      CELL_LOAD:  data_nxt = load_data;
      CELL_LEFT:  data_nxt = left_data;
      CELL_RIGHT: data_nxt = right_data;
      default:    data_nxt = data_r;
    endcase
  end

  // Payload only: no reset, contents are undefined until written.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

FILE: hdl/bounded_array_list.sv
// Top level of the bounded array list: a row of entry cells plus count and result register.
//
//   channel | ports                                          | direction
//   --------+------------------------------------------------+----------
//   in      | in_valid/in_ready, in_func, in_value,           | request
//           | in_position                                    |
//   out     | out_valid/out_ready, out_ok, out_read_value,    | result
//           | out_count                                      |
//
// Each request word is decoded and carried out in the cycle it is accepted:
// every cell loads, shifts from a neighbor or holds in that same edge, so one
// word per cycle is taken while the result is not stalled. The result word
// sits in an output register the next cycle. Reset clears the element count
// and the output valid; cell contents are left as they are. A stalled result
// holds in its register and blocks new words only while out_ready stays low.
module bounded_array_list #(
  parameter int DEPTH = bal_pkg::DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            in_func,
  input  logic signed [bal_pkg::DATA_W-1:0]     in_value,
  input  logic [bal_pkg::POS_W-1:0]             in_position,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_ok,
  output logic signed [bal_pkg::DATA_W-1:0]     out_read_value,
  output logic [bal_pkg::CNT_OUT_W-1:0]         out_count
);
  import bal_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  // Compare width wide enough for both position and count.
  localparam int AW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0]            count_r;
  logic [CW-1:0]            count_nxt;
  logic                     out_valid_r;
  logic                     out_ok_r;
  logic signed [DATA_W-1:0] out_read_value_r;
  logic [CNT_OUT_W-1:0]     out_count_r;

  logic                     accept;
  logic [AW-1:0]            pos_ext;
  logic [AW-1:0]            cnt_ext;
  logic                     not_full;
  logic                     in_range;
  logic                     ok_nxt;
  logic signed [DATA_W-1:0] rd_nxt;
  logic signed [DATA_W-1:0] sel_q;
  bal_op_t                  op;

  logic signed [DATA_W-1:0] cell_q [DEPTH];

  // Take a new word whenever the result register is empty or being drained.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign op       = bal_op_t'(in_func);
  assign pos_ext  = AW'(in_position);
  assign cnt_ext  = AW'(count_r);
  assign not_full = (count_r != CW'(DEPTH));
  // position below count also keeps it below DEPTH, since count never exceeds DEPTH
  assign in_range = (pos_ext < cnt_ext);

  // Select the entry at the requested position for reads.
  always_comb begin
    sel_q = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (pos_ext == AW'(i)) begin
        sel_q = cell_q[i];
      end
    end
  end

  // Decide the outcome and the new count.
  always_comb begin
    ok_nxt    = 1'b0;
    rd_nxt    = '0;
    count_nxt = count_r;
    case (op)
      OP_APPEND, OP_INSERT: begin
        if (not_full) begin
          ok_nxt    = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      OP_DELETE: begin
        if (in_range) begin
          ok_nxt    = 1'b1;
          count_nxt = count_r - CW'(1);
        end
      end
      OP_READ: begin
        if (in_range) begin
          ok_nxt = 1'b1;
          rd_nxt = sel_q;
        end
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  // Per-cell control: load at the tail on append, load at the head and shift
  // right on insert, shift left from the deleted slot onward on delete.
  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [AW-1:0] IDX = AW'(i);
      logic signed [DATA_W-1:0] left_d;
      logic signed [DATA_W-1:0] right_d;
      bal_cell_mode_t           mode_c;

      always_comb begin
        mode_c = CELL_HOLD;
        if (accept && ok_nxt) begin
          case (op)
            OP_APPEND: begin
              if (cnt_ext == IDX) begin
                mode_c = CELL_LOAD;
              end
            end
            OP_INSERT: begin
              if (i == 0) begin
                mode_c = CELL_LOAD;
              end else begin
                mode_c = CELL_LEFT;
              end
            end
            OP_DELETE: begin
              if ((IDX >= pos_ext) && (i < DEPTH - 1)) begin
                mode_c = CELL_RIGHT;
              end
            end
            default: begin
              mode_c = CELL_HOLD;
            end
          endcase
        end
      end

      if (i == 0) begin : g_head
        assign left_d = in_value;
      end else begin : g_body
        assign left_d = cell_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
        assign right_d = cell_q[i];
      end else begin : g_inner
        assign right_d = cell_q[i+1];
      end

      bal_cell u_cell (
        .clk       (clk),
        .mode      (mode_c),
        .load_data (in_value),
        .left_data (left_d),
        .right_data(right_d),
        .q         (cell_q[i])
      );
    end
  endgenerate

  // Control state: element count and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: capture on accept, hold while stalled.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_ok_r         <= ok_nxt;
      out_read_value_r <= rd_nxt;
      out_count_r      <= CNT_OUT_W'(count_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_read_value = out_read_value_r;
  assign out_count      = out_count_r;

endmodule
